FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the neighbor table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define NTA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define NTA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/nta_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor table package
// Field widths, codes and the stored entry layout of the neighbor table.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int MODE_W        = 2;
    localparam int IP_W          = 64;
    localparam int MAC_W         = 48;
    localparam int TIME_W        = 32;
    localparam int AGE_W         = 16;
    localparam int STATUS_W      = 3;
    localparam int INDEX_W       = 4;
    localparam int USE_W         = 5;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd120;

    localparam logic [MODE_W-1:0] MODE_FIND_MAC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEARN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LEARN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWEEP = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [IP_W-1:0]   ip_hi;
        logic [IP_W-1:0]   ip_lo;
        logic [MAC_W-1:0]  mac;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

FILE: rtl/core/nta_if.sv
// ----------------------------------------------------------------------------
// Neighbor table channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nta_req_if import nta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IP_W-1:0]   ip_hi;
    logic [IP_W-1:0]   ip_lo;
    logic [MAC_W-1:0]  mac_addr;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, mode, ip_hi, ip_lo, mac_addr, now_seconds, input ready);
    modport sink (input valid, mode, ip_hi, ip_lo, mac_addr, now_seconds, output ready);
endinterface

interface nta_rsp_if import nta_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [MAC_W-1:0]    mac_out;
    logic [IP_W-1:0]     ip_hi_out;
    logic [IP_W-1:0]     ip_lo_out;
    logic [USE_W-1:0]    entries_in_use;

    modport source (output valid, status, entry_index, mac_out, ip_hi_out, ip_lo_out,
                    entries_in_use, input ready);
    modport sink (input valid, status, entry_index, mac_out, ip_hi_out, ip_lo_out,
                  entries_in_use, output ready);
endinterface

interface nta_cfg_if import nta_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AGE_W-1:0] max_age;

    modport source (output valid, max_age, input ready);
    modport sink (input valid, max_age, output ready);
endinterface

FILE: rtl/core/nta_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module nta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/neighbor_table_with_aging.sv
// ----------------------------------------------------------------------------
// Neighbor table with aging
// Ordered IPv6 to MAC table in one RAM, walked entry by entry for lookups,
// learning and compaction of aged entries.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  cfg      in         write of max_age
//  req      in         mode, ip_hi, ip_lo, mac_addr, now_seconds
//  rsp      out        status, entry_index, mac_out, ip_hi_out, ip_lo_out,
//                      entries_in_use
//
// A new request is accepted only in the idle state, after the previous one
// has passed the done state; a hit ends the walk at the matching entry.
// The walk reads one entry per cycle and checks it on the registered RAM read
// data; an end check, the done state and the idle state then follow.
// Reset empties the table and sets max_age to 120.
// A stalled response holds the finished result while the next request is
// walked; that request finishes only once the response register is free.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging
    import nta_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    nta_cfg_if.sink   cfg,
    nta_req_if.sink   req,
    nta_rsp_if.source rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              rsp_vld_reg, rsp_vld_next;
    logic [AGE_W-1:0]  max_age_reg, max_age_next;

    logic [MODE_W-1:0] mode_reg, mode_next;
    entry_t            item_reg, item_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [MAC_W-1:0]    res_mac_reg, res_mac_next;
    logic [IP_W-1:0]     res_ip_hi_reg, res_ip_hi_next;
    logic [IP_W-1:0]     res_ip_lo_reg, res_ip_lo_next;

    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [INDEX_W-1:0]  rsp_index_reg, rsp_index_next;
    logic [MAC_W-1:0]    rsp_mac_reg, rsp_mac_next;
    logic [IP_W-1:0]     rsp_ip_hi_reg, rsp_ip_hi_next;
    logic [IP_W-1:0]     rsp_ip_lo_reg, rsp_ip_lo_next;
    logic [USE_W-1:0]    rsp_use_reg, rsp_use_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    entry_t              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t              rd_entry;
    entry_t              hit_entry;
    logic                survive;

    nta_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_raddr = rd_ptr_reg[IDX_W-1:0];
    assign survive   = ({1'b0, rd_entry.stamp} + {{(TIME_W - AGE_W + 1){1'b0}}, max_age_reg})
                       >= {1'b0, item_reg.stamp};

    always_comb
    begin
        hit_entry       = rd_entry;
        hit_entry.stamp = item_reg.stamp;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_idx_next    = chk_idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        chk_vld_next    = chk_vld_reg;
        rsp_vld_next    = rsp_vld_reg;
        max_age_next    = max_age_reg;
        mode_next       = mode_reg;
        item_next       = item_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_mac_next    = res_mac_reg;
        res_ip_hi_next  = res_ip_hi_reg;
        res_ip_lo_next  = res_ip_lo_reg;
        rsp_status_next = rsp_status_reg;
        rsp_index_next  = rsp_index_reg;
        rsp_mac_next    = rsp_mac_reg;
        rsp_ip_hi_next  = rsp_ip_hi_reg;
        rsp_ip_lo_next  = rsp_ip_lo_reg;
        rsp_use_next    = rsp_use_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg[IDX_W-1:0];
        ram_wdata       = rd_entry;

        if (cfg.valid)
        begin
            max_age_next = cfg.max_age;
        end

        if (rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next      = req.mode;
                    item_next      = '{stamp: req.now_seconds, ip_hi: req.ip_hi,
                                       ip_lo: req.ip_lo, mac: req.mac_addr};
                    rd_ptr_next    = '0;
                    wr_ptr_next    = '0;
                    chk_vld_next   = 1'b0;
                    res_status_next = ST_MISS;
                    res_index_next = '0;
                    res_mac_next   = '0;
                    res_ip_hi_next = '0;
                    res_ip_lo_next = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                    chk_idx_next = rd_ptr_reg;
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                if (chk_vld_reg)
                begin
                    priority if (mode_reg == MODE_FIND_MAC &&
                                 rd_entry.ip_hi == item_reg.ip_hi &&
                                 rd_entry.ip_lo == item_reg.ip_lo)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = chk_idx_reg[IDX_W-1:0];
                        ram_wdata       = hit_entry;
                        res_status_next = ST_HIT;
                        res_index_next  = INDEX_W'(chk_idx_reg);
                        res_mac_next    = rd_entry.mac;
                        state_next      = S_DONE;
                    end
                    else if (mode_reg == MODE_LEARN && rd_entry.mac == item_reg.mac)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = chk_idx_reg[IDX_W-1:0];
                        ram_wdata       = hit_entry;
                        res_status_next = ST_HIT;
                        res_index_next  = INDEX_W'(chk_idx_reg);
                        res_ip_hi_next  = rd_entry.ip_hi;
                        res_ip_lo_next  = rd_entry.ip_lo;
                        state_next      = S_DONE;
                    end
                    else if (mode_reg == MODE_SWEEP && survive)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = wr_ptr_reg[IDX_W-1:0];
                        ram_wdata   = rd_entry;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                    else
                    begin
                        ram_we = 1'b0;
                    end
                end
                else if (rd_ptr_reg >= count_reg)
                begin
                    state_next = S_DONE;
                    if (mode_reg == MODE_LEARN)
                    begin
                        if (count_reg < FULL_COUNT)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = count_reg[IDX_W-1:0];
                            ram_wdata       = item_reg;
                            count_next      = count_reg + 1'b1;
                            res_status_next = ST_LEARN;
                            res_index_next  = INDEX_W'(count_reg);
                            res_ip_hi_next  = item_reg.ip_hi;
                            res_ip_lo_next  = item_reg.ip_lo;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    else if (mode_reg == MODE_SWEEP)
                    begin
                        count_next      = wr_ptr_reg;
                        res_status_next = ST_SWEEP;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next    = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_index_next  = res_index_reg;
                    rsp_mac_next    = res_mac_reg;
                    rsp_ip_hi_next  = res_ip_hi_reg;
                    rsp_ip_lo_next  = res_ip_lo_reg;
                    rsp_use_next    = USE_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_ptr_reg  <= '0;
            chk_idx_reg <= '0;
            wr_ptr_reg  <= '0;
            chk_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            max_age_reg <= MAX_AGE_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_ptr_reg  <= rd_ptr_next;
            chk_idx_reg <= chk_idx_next;
            wr_ptr_reg  <= wr_ptr_next;
            chk_vld_reg <= chk_vld_next;
            rsp_vld_reg <= rsp_vld_next;
            max_age_reg <= max_age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_mac_reg    <= res_mac_next;
        res_ip_hi_reg  <= res_ip_hi_next;
        res_ip_lo_reg  <= res_ip_lo_next;
        rsp_status_reg <= rsp_status_next;
        rsp_index_reg  <= rsp_index_next;
        rsp_mac_reg    <= rsp_mac_next;
        rsp_ip_hi_reg  <= rsp_ip_hi_next;
        rsp_ip_lo_reg  <= rsp_ip_lo_next;
        rsp_use_reg    <= rsp_use_next;
    end

    assign cfg.ready          = 1'b1;
    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_vld_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.entry_index    = rsp_index_reg;
    assign rsp.mac_out        = rsp_mac_reg;
    assign rsp.ip_hi_out      = rsp_ip_hi_reg;
    assign rsp.ip_lo_out      = rsp_ip_lo_reg;
    assign rsp.entries_in_use = rsp_use_reg;

`include "assert_macros.svh"

    `NTA_ASSERT_ALWAYS(a_count_bound, clk, count_reg <= FULL_COUNT, "entry count above table size")
    `NTA_ASSERT(a_rd_ptr_bound, clk, rst_n, (state_reg == S_SCAN) |-> (rd_ptr_reg <= count_reg), "read pointer ran past the valid entries")
    `NTA_ASSERT(a_compact_order, clk, rst_n, (state_reg == S_SCAN && chk_vld_reg) |-> (wr_ptr_reg <= chk_idx_reg), "compaction write overtook the read")
    `NTA_ASSERT(a_rsp_from_done, clk, rst_n, $rose(rsp_vld_reg) |-> $past(state_reg == S_DONE), "response raised outside the done state")

endmodule
